// ===== design/credential_cache_stream_parser_assert.svh =====
// Assertion macros used by the checker file ccsp_checker.sv.
`ifndef CREDENTIAL_CACHE_STREAM_PARSER_ASSERT_SVH
`define CREDENTIAL_CACHE_STREAM_PARSER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define CCSP_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ccsp assertion failed");

// Next-cycle implication, disabled during reset.
`define CCSP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ccsp assertion failed");

`endif

// ===== design/ccsp_pkg.sv =====
`timescale 1ns / 1ps

package ccsp_pkg;

    localparam logic [4:0] PH_NONE      = 5'd0;
    localparam logic [4:0] PH_VERSION   = 5'd1;
    localparam logic [4:0] PH_HDRLEN    = 5'd2;
    localparam logic [4:0] PH_HDRBYTE   = 5'd3;
    localparam logic [4:0] PH_NAMETYPE  = 5'd4;
    localparam logic [4:0] PH_NCOMP     = 5'd5;
    localparam logic [4:0] PH_REALMLEN  = 5'd6;
    localparam logic [4:0] PH_REALMBYTE = 5'd7;
    localparam logic [4:0] PH_COMPLEN   = 5'd8;
    localparam logic [4:0] PH_COMPBYTE  = 5'd9;
    localparam logic [4:0] PH_KEYTYPE   = 5'd10;
    localparam logic [4:0] PH_KEYLEN    = 5'd12;
    localparam logic [4:0] PH_KEYBYTE   = 5'd13;
    localparam logic [4:0] PH_AUTHTIME  = 5'd14;
    localparam logic [4:0] PH_FLAGS     = 5'd19;
    localparam logic [4:0] PH_NADDR     = 5'd20;
    localparam logic [4:0] PH_ADDRTYPE  = 5'd21;
    localparam logic [4:0] PH_ADDRLEN   = 5'd22;
    localparam logic [4:0] PH_ADDRBYTE  = 5'd23;
    localparam logic [4:0] PH_NAUTH     = 5'd24;
    localparam logic [4:0] PH_AUTHTYPE  = 5'd25;
    localparam logic [4:0] PH_AUTHLEN   = 5'd26;
    localparam logic [4:0] PH_AUTHBYTE  = 5'd27;
    localparam logic [4:0] PH_TKTLEN    = 5'd28;
    localparam logic [4:0] PH_TKTBYTE   = 5'd29;
    localparam logic [4:0] PH_TKT2LEN   = 5'd30;
    localparam logic [4:0] PH_TKT2BYTE  = 5'd31;

    localparam logic [1:0] ROLE_DEFAULT = 2'd0;
    localparam logic [1:0] ROLE_CLIENT  = 2'd1;
    localparam logic [1:0] ROLE_SERVER  = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_TRUNC     = 2'd1;
    localparam logic [1:0] ST_NCOMP     = 2'd2;
    localparam logic [1:0] ST_TERM      = 2'd3;

    localparam logic [7:0] TERM_BYTE    = 8'h00;

    typedef struct packed {
        logic [4:0]  phase;
        logic [1:0]  byte_of_field;
        logic [31:0] value_shift;
        logic [31:0] bytes_remaining;
        logic [31:0] entries_left;
        logic [1:0]  role;
        logic [3:0]  component_index;
        logic        check_terminator;
        logic [1:0]  error_code;
    } ccsp_state_t;

    typedef struct packed {
        logic [4:0]  field_code;
        logic [31:0] field_value;
        logic        value_complete;
        logic [1:0]  principal_role;
        logic [3:0]  component_number;
        logic        record_done;
        logic [1:0]  status;
    } ccsp_result_t;

    localparam ccsp_state_t STATE_RESET = '{
        phase: PH_VERSION, byte_of_field: 2'd0, value_shift: 32'd0,
        bytes_remaining: 32'd0, entries_left: 32'd0, role: ROLE_DEFAULT,
        component_index: 4'd0, check_terminator: 1'b0, error_code: ST_OK};

    // Byte count of each numeric field; zero marks a string-byte phase.
    function automatic logic [2:0] field_size(input logic [4:0] p);
        logic [2:0] s;
        case (p)
            5'd1, 5'd2, 5'd10, 5'd11, 5'd12, 5'd21, 5'd25: s = 3'd2;
            5'd4, 5'd5, 5'd6, 5'd8, 5'd14, 5'd15, 5'd16, 5'd17,
            5'd19, 5'd20, 5'd22, 5'd24, 5'd26, 5'd28, 5'd30: s = 3'd4;
            5'd18: s = 3'd1;
            default: s = 3'd0;
        endcase
        return s;
    endfunction

endpackage

// ===== design/ccsp_step.sv =====
`timescale 1ns / 1ps

module ccsp_step #(
    parameter int MAX_COMPONENTS = 16,
    parameter int CL_W = $clog2(MAX_COMPONENTS + 1)
) (
    input  ccsp_pkg::ccsp_state_t  cur,
    input  logic [CL_W-1:0]        cl_cur,
    input  logic [7:0]             byte_value,
    input  logic                   last_byte,
    output ccsp_pkg::ccsp_state_t  nxt,
    output logic [CL_W-1:0]        cl_nxt,
    output ccsp_pkg::ccsp_result_t res
);

    always_comb
    begin
        logic [4:0]  p;
        logic [2:0]  size;
        logic [2:0]  n;
        logic        go_en;
        logic [4:0]  go_ph;
        logic        realm_e;
        logic        comp_e;
        logic        addr_e;
        logic        auth_e;
        logic        cred_e;
        logic [31:0] v;

        nxt     = cur;
        cl_nxt  = cl_cur;
        res     = '0;
        go_en   = 1'b0;
        go_ph   = ccsp_pkg::PH_NONE;
        realm_e = 1'b0;
        comp_e  = 1'b0;
        addr_e  = 1'b0;
        auth_e  = 1'b0;
        cred_e  = 1'b0;
        p       = cur.phase;
        size    = ccsp_pkg::field_size(p);
        n       = {1'b0, cur.byte_of_field} + 3'd1;
        v       = '0;

        if (nxt.error_code == ccsp_pkg::ST_OK && nxt.check_terminator)
        begin
            nxt.check_terminator = 1'b0;
            if (byte_value != ccsp_pkg::TERM_BYTE)
                nxt.error_code = ccsp_pkg::ST_TERM;
        end

        if (nxt.error_code == ccsp_pkg::ST_OK)
        begin
            res.field_code = p;
            if (p >= ccsp_pkg::PH_NAMETYPE && p <= ccsp_pkg::PH_COMPBYTE)
                res.principal_role = cur.role;
            if (p == ccsp_pkg::PH_COMPLEN || p == ccsp_pkg::PH_COMPBYTE)
                res.component_number = cur.component_index;
            if (size == 3'd0)
            begin
                res.field_value = {24'd0, byte_value};
                nxt.bytes_remaining = cur.bytes_remaining - 32'd1;
                if (nxt.bytes_remaining == 32'd0)
                begin
                    res.value_complete = 1'b1;
                    case (p)
                        ccsp_pkg::PH_HDRBYTE:
                        begin
                            go_en = 1'b1;
                            go_ph = ccsp_pkg::PH_NAMETYPE;
                        end
                        ccsp_pkg::PH_REALMBYTE: realm_e = 1'b1;
                        ccsp_pkg::PH_COMPBYTE:  comp_e  = 1'b1;
                        ccsp_pkg::PH_KEYBYTE:
                        begin
                            go_en = 1'b1;
                            go_ph = ccsp_pkg::PH_AUTHTIME;
                        end
                        ccsp_pkg::PH_ADDRBYTE:  addr_e  = 1'b1;
                        ccsp_pkg::PH_AUTHBYTE:  auth_e  = 1'b1;
                        ccsp_pkg::PH_TKTBYTE:
                        begin
                            go_en = 1'b1;
                            go_ph = ccsp_pkg::PH_TKT2LEN;
                        end
                        default: cred_e = 1'b1;
                    endcase
                end
            end
            else
            begin
                // Ticket flags arrive little-endian; all else big-endian.
                if (p == ccsp_pkg::PH_FLAGS)
                    v = cur.value_shift
                        | ({24'd0, byte_value} << {cur.byte_of_field, 3'b000});
                else
                    v = {cur.value_shift[23:0], byte_value};
                nxt.value_shift = v;
                res.field_value = v;
                if (n >= size)
                begin
                    res.value_complete = 1'b1;
                    case (p)
                        ccsp_pkg::PH_HDRLEN:
                        begin
                            nxt.bytes_remaining = v;
                            go_en = 1'b1;
                            go_ph = (v == 32'd0) ? ccsp_pkg::PH_NAMETYPE
                                                 : ccsp_pkg::PH_HDRBYTE;
                        end
                        ccsp_pkg::PH_NCOMP:
                        begin
                            if (v >= 32'(MAX_COMPONENTS))
                                nxt.error_code = ccsp_pkg::ST_NCOMP;
                            else
                            begin
                                cl_nxt = v[CL_W-1:0];
                                nxt.component_index = 4'd0;
                                go_en = 1'b1;
                                go_ph = ccsp_pkg::PH_REALMLEN;
                            end
                        end
                        ccsp_pkg::PH_REALMLEN:
                        begin
                            nxt.bytes_remaining = v;
                            if (v == 32'd0)
                                realm_e = 1'b1;
                            else
                            begin
                                go_en = 1'b1;
                                go_ph = ccsp_pkg::PH_REALMBYTE;
                            end
                        end
                        ccsp_pkg::PH_COMPLEN:
                        begin
                            nxt.bytes_remaining = v;
                            if (v == 32'd0)
                                comp_e = 1'b1;
                            else
                            begin
                                go_en = 1'b1;
                                go_ph = ccsp_pkg::PH_COMPBYTE;
                            end
                        end
                        ccsp_pkg::PH_KEYLEN:
                        begin
                            nxt.bytes_remaining = v;
                            go_en = 1'b1;
                            go_ph = (v == 32'd0) ? ccsp_pkg::PH_AUTHTIME
                                                 : ccsp_pkg::PH_KEYBYTE;
                        end
                        ccsp_pkg::PH_NADDR:
                        begin
                            nxt.entries_left = v;
                            go_en = 1'b1;
                            go_ph = (v == 32'd0) ? ccsp_pkg::PH_NAUTH
                                                 : ccsp_pkg::PH_ADDRTYPE;
                        end
                        ccsp_pkg::PH_ADDRLEN:
                        begin
                            nxt.bytes_remaining = v;
                            if (v == 32'd0)
                                addr_e = 1'b1;
                            else
                            begin
                                go_en = 1'b1;
                                go_ph = ccsp_pkg::PH_ADDRBYTE;
                            end
                        end
                        ccsp_pkg::PH_NAUTH:
                        begin
                            nxt.entries_left = v;
                            go_en = 1'b1;
                            go_ph = (v == 32'd0) ? ccsp_pkg::PH_TKTLEN
                                                 : ccsp_pkg::PH_AUTHTYPE;
                        end
                        ccsp_pkg::PH_AUTHLEN:
                        begin
                            nxt.bytes_remaining = v;
                            if (v == 32'd0)
                                auth_e = 1'b1;
                            else
                            begin
                                go_en = 1'b1;
                                go_ph = ccsp_pkg::PH_AUTHBYTE;
                            end
                        end
                        ccsp_pkg::PH_TKTLEN:
                        begin
                            nxt.bytes_remaining = v;
                            go_en = 1'b1;
                            go_ph = (v == 32'd0) ? ccsp_pkg::PH_TKT2LEN
                                                 : ccsp_pkg::PH_TKTBYTE;
                        end
                        ccsp_pkg::PH_TKT2LEN:
                        begin
                            nxt.bytes_remaining = v;
                            if (v == 32'd0)
                                cred_e = 1'b1;
                            else
                            begin
                                go_en = 1'b1;
                                go_ph = ccsp_pkg::PH_TKT2BYTE;
                            end
                        end
                        default:
                        begin
                            go_en = 1'b1;
                            go_ph = p + 5'd1;
                        end
                    endcase
                end
                else
                    nxt.byte_of_field = n[1:0];
            end

            // Close realm or component, then move to the next component, principal or key type.
            if (comp_e)
            begin
                cl_nxt = cl_cur - CL_W'(1);
                nxt.component_index = cur.component_index + 4'd1;
            end
            if (realm_e || comp_e)
            begin
                nxt.check_terminator = 1'b1;
                go_en = 1'b1;
                if (cl_nxt != '0)
                    go_ph = ccsp_pkg::PH_COMPLEN;
                else if (cur.role == ccsp_pkg::ROLE_DEFAULT)
                begin
                    nxt.role = ccsp_pkg::ROLE_CLIENT;
                    go_ph = ccsp_pkg::PH_NAMETYPE;
                    res.record_done = 1'b1;
                end
                else if (cur.role == ccsp_pkg::ROLE_CLIENT)
                begin
                    nxt.role = ccsp_pkg::ROLE_SERVER;
                    go_ph = ccsp_pkg::PH_NAMETYPE;
                end
                else
                    go_ph = ccsp_pkg::PH_KEYTYPE;
            end
            if (addr_e || auth_e)
            begin
                nxt.entries_left = nxt.entries_left - 32'd1;
                go_en = 1'b1;
                if (addr_e)
                    go_ph = (nxt.entries_left == 32'd0) ? ccsp_pkg::PH_NAUTH
                                                        : ccsp_pkg::PH_ADDRTYPE;
                else
                    go_ph = (nxt.entries_left == 32'd0) ? ccsp_pkg::PH_TKTLEN
                                                        : ccsp_pkg::PH_AUTHTYPE;
            end
            if (cred_e)
            begin
                nxt.role = ccsp_pkg::ROLE_CLIENT;
                go_en = 1'b1;
                go_ph = ccsp_pkg::PH_NAMETYPE;
                res.record_done = 1'b1;
            end
            if (go_en)
            begin
                nxt.phase = go_ph;
                nxt.byte_of_field = 2'd0;
                nxt.value_shift = 32'd0;
            end
        end

        res.status = nxt.error_code;
        if (last_byte)
        begin
            if (nxt.error_code == ccsp_pkg::ST_OK
                && !(nxt.phase == ccsp_pkg::PH_NAMETYPE
                     && nxt.role == ccsp_pkg::ROLE_CLIENT
                     && nxt.byte_of_field == 2'd0))
                res.status = ccsp_pkg::ST_TRUNC;
            nxt = ccsp_pkg::STATE_RESET;
            cl_nxt = '0;
        end
    end

endmodule

// ===== design/credential_cache_stream_parser.sv =====
`timescale 1ns / 1ps
// Credential cache stream parser.
// Input channel: byte_value and last_byte with item_valid / item_stall.
// Each accepted word is one byte of the cache file; last_byte marks the
// final byte of the buffer.
// Output channel: one tagged result per input word, with result_valid /
// result_stall: field_code, field_value, value_complete, principal_role,
// component_number, record_done and status.
// The result of a word is registered and shown the cycle after it is accepted.
// Throughput: one word per cycle unless stalled; the parse state update
// is a single pass of combinational logic from the state register into
// the result register. The input is taken while a result waits, as long
// as that result leaves in the same cycle; item_stall is high only when
// the result register is full and the receiver stalls.
// Reset clears the parse state to the version field with no error pending
// and empties the result register. A stalled result holds unchanged.
// Errors are sticky until a last byte, which returns the parser to reset.

module credential_cache_stream_parser #(
    parameter int MAX_COMPONENTS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_stall,
    input  logic [7:0]  byte_value,
    input  logic        last_byte,
    output logic        result_valid,
    input  logic        result_stall,
    output logic [4:0]  field_code,
    output logic [31:0] field_value,
    output logic        value_complete,
    output logic [1:0]  principal_role,
    output logic [3:0]  component_number,
    output logic        record_done,
    output logic [1:0]  status
);

    localparam int CL_W = $clog2(MAX_COMPONENTS + 1);

    ccsp_pkg::ccsp_state_t  state_reg;
    ccsp_pkg::ccsp_state_t  state_next;
    logic [CL_W-1:0]        comps_left_reg;
    logic [CL_W-1:0]        comps_left_next;
    ccsp_pkg::ccsp_result_t result_reg;
    ccsp_pkg::ccsp_result_t result_next;
    logic                   valid_reg;
    logic                   accept;

    // Stall only while a full result register cannot drain.
    assign item_stall = valid_reg && result_stall;
    assign accept     = item_valid && !item_stall;

    ccsp_step #(
        .MAX_COMPONENTS(MAX_COMPONENTS),
        .CL_W(CL_W)
    ) u_step (
        .cur(state_reg),
        .cl_cur(comps_left_reg),
        .byte_value(byte_value),
        .last_byte(last_byte),
        .nxt(state_next),
        .cl_nxt(comps_left_next),
        .res(result_next)
    );

    // Advance parse state on every accepted word.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ccsp_pkg::STATE_RESET;
            comps_left_reg <= '0;
            valid_reg      <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                state_reg      <= state_next;
                comps_left_reg <= comps_left_next;
            end
            if (accept)
                valid_reg <= 1'b1;
            else if (!result_stall)
                valid_reg <= 1'b0;
        end
    end

    // Result payload: load on accept, hold otherwise.
    always_ff @(posedge clk)
    begin
        if (accept)
            result_reg <= result_next;
    end

    assign result_valid     = valid_reg;
    assign field_code       = result_reg.field_code;
    assign field_value      = result_reg.field_value;
    assign value_complete   = result_reg.value_complete;
    assign principal_role   = result_reg.principal_role;
    assign component_number = result_reg.component_number;
    assign record_done      = result_reg.record_done;
    assign status           = result_reg.status;

endmodule

// ===== design/ccsp_checker.sv =====
`timescale 1ns / 1ps
`include "credential_cache_stream_parser_assert.svh"

module ccsp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        item_stall,
    input logic        result_valid,
    input logic        result_stall,
    input logic [4:0]  field_code,
    input logic [31:0] field_value,
    input logic        value_complete,
    input logic [3:0]  component_number,
    input logic        record_done,
    input logic [1:0]  status
);

    // A stalled result holds.
    `CCSP_ASSERT_NEXT(a_hold, result_valid && result_stall, result_valid && $stable(field_code) && $stable(field_value) && $stable(status))

    // Input stalls only behind a full, stalled result.
    `CCSP_ASSERT_NOW(a_stall, item_stall, result_valid && result_stall)

    // A terminator error leaves nothing parsed; only its status shows.
    `CCSP_ASSERT_NOW(a_err, result_valid && (status == ccsp_pkg::ST_TERM), field_code == ccsp_pkg::PH_NONE && field_value == 32'd0 && !record_done)

    // Records end only on a completed field; component index only on components.
    `CCSP_ASSERT_NOW(a_done, result_valid && (record_done || (component_number != 4'd0)), (value_complete || !record_done) && (field_code == ccsp_pkg::PH_COMPLEN || field_code == ccsp_pkg::PH_COMPBYTE || component_number == 4'd0))

endmodule

bind credential_cache_stream_parser ccsp_checker u_ccsp_checker (
    .clk(clk),
    .rst_n(rst_n),
    .item_stall(item_stall),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .field_code(field_code),
    .field_value(field_value),
    .value_complete(value_complete),
    .component_number(component_number),
    .record_done(record_done),
    .status(status)
);

// ===== sim/ccsp_result_checker.sv =====
`timescale 1ns / 1ps

module ccsp_result_checker #(
    parameter int MAX_COMPONENTS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    input  logic        item_stall,
    input  logic [7:0]  byte_value,
    input  logic        last_byte,
    input  logic        result_valid,
    input  logic        result_stall,
    input  logic [4:0]  field_code,
    input  logic [31:0] field_value,
    input  logic        value_complete,
    input  logic [1:0]  principal_role,
    input  logic [3:0]  component_number,
    input  logic        record_done,
    input  logic [1:0]  status,
    output int          error_count,
    output int          pending_count
);

    localparam logic [4:0] PH_ETYPE = 5'd11;
    localparam logic [4:0] PH_SKEY  = 5'd18;

    logic [4:0]  cur_phase;
    logic [1:0]  cur_byte_idx;
    logic [31:0] cur_accum;
    logic [31:0] cur_remaining;
    logic [6:0]  cur_comps_left;
    logic [31:0] cur_entries;
    logic [1:0]  cur_role;
    logic [3:0]  cur_comp_idx;
    logic        cur_check_term;
    logic [1:0]  cur_error;

    ccsp_pkg::ccsp_result_t expected_results[$];

    function automatic int numeric_size(input logic [4:0] p);
        case (p)
            ccsp_pkg::PH_VERSION, ccsp_pkg::PH_HDRLEN, ccsp_pkg::PH_KEYTYPE, PH_ETYPE,
            ccsp_pkg::PH_KEYLEN, ccsp_pkg::PH_ADDRTYPE, ccsp_pkg::PH_AUTHTYPE: return 2;
            PH_SKEY: return 1;
            ccsp_pkg::PH_HDRBYTE, ccsp_pkg::PH_REALMBYTE, ccsp_pkg::PH_COMPBYTE,
            ccsp_pkg::PH_KEYBYTE, ccsp_pkg::PH_ADDRBYTE, ccsp_pkg::PH_AUTHBYTE,
            ccsp_pkg::PH_TKTBYTE, ccsp_pkg::PH_TKT2BYTE, ccsp_pkg::PH_NONE: return 0;
            default: return 4;
        endcase
    endfunction

    function automatic void parser_clear();
        cur_phase = ccsp_pkg::PH_VERSION;
        cur_byte_idx = 0;
        cur_accum = 0;
        cur_remaining = 0;
        cur_comps_left = 0;
        cur_entries = 0;
        cur_role = ccsp_pkg::ROLE_DEFAULT;
        cur_comp_idx = 0;
        cur_check_term = 0;
        cur_error = ccsp_pkg::ST_OK;
    endfunction

    function automatic void enter(input logic [4:0] p);
        cur_phase = p;
        cur_byte_idx = 0;
        cur_accum = 0;
    endfunction

    function automatic void flag_error(input logic [1:0] e);
        if (cur_error == ccsp_pkg::ST_OK)
            cur_error = e;
    endfunction

    function automatic logic end_principal();
        if (cur_role == ccsp_pkg::ROLE_DEFAULT)
        begin
            cur_role = ccsp_pkg::ROLE_CLIENT;
            enter(ccsp_pkg::PH_NAMETYPE);
            return 1'b1;
        end
        if (cur_role == ccsp_pkg::ROLE_CLIENT)
        begin
            cur_role = ccsp_pkg::ROLE_SERVER;
            enter(ccsp_pkg::PH_NAMETYPE);
            return 1'b0;
        end
        enter(ccsp_pkg::PH_KEYTYPE);
        return 1'b0;
    endfunction

    function automatic logic next_component();
        if (cur_comps_left == 0)
            return end_principal();
        enter(ccsp_pkg::PH_COMPLEN);
        return 1'b0;
    endfunction

    function automatic logic end_component();
        cur_check_term = 1;
        cur_comps_left = cur_comps_left - 7'd1;
        cur_comp_idx = cur_comp_idx + 4'd1;
        return next_component();
    endfunction

    function automatic logic end_credential();
        cur_role = ccsp_pkg::ROLE_CLIENT;
        enter(ccsp_pkg::PH_NAMETYPE);
        return 1'b1;
    endfunction

    function automatic void end_addr();
        cur_entries = cur_entries - 1;
        enter(cur_entries == 0 ? ccsp_pkg::PH_NAUTH : ccsp_pkg::PH_ADDRTYPE);
    endfunction

    function automatic void end_auth();
        cur_entries = cur_entries - 1;
        enter(cur_entries == 0 ? ccsp_pkg::PH_TKTLEN : ccsp_pkg::PH_AUTHTYPE);
    endfunction

    function automatic logic finish_string(input logic [4:0] p);
        case (p)
            ccsp_pkg::PH_HDRBYTE: enter(ccsp_pkg::PH_NAMETYPE);
            ccsp_pkg::PH_REALMBYTE:
            begin
                cur_check_term = 1;
                return next_component();
            end
            ccsp_pkg::PH_COMPBYTE: return end_component();
            ccsp_pkg::PH_KEYBYTE: enter(ccsp_pkg::PH_AUTHTIME);
            ccsp_pkg::PH_ADDRBYTE: end_addr();
            ccsp_pkg::PH_AUTHBYTE: end_auth();
            ccsp_pkg::PH_TKTBYTE: enter(ccsp_pkg::PH_TKT2LEN);
            default: return end_credential();
        endcase
        return 1'b0;
    endfunction

    function automatic logic finish_number(input logic [4:0] p, input logic [31:0] v);
        cur_remaining = v;
        case (p)
            ccsp_pkg::PH_HDRLEN:
                enter(v == 0 ? ccsp_pkg::PH_NAMETYPE : ccsp_pkg::PH_HDRBYTE);
            ccsp_pkg::PH_NCOMP:
            begin
                if (v >= MAX_COMPONENTS)
                    flag_error(ccsp_pkg::ST_NCOMP);
                else
                begin
                    cur_comps_left = v[6:0];
                    cur_comp_idx = 0;
                    enter(ccsp_pkg::PH_REALMLEN);
                end
            end
            ccsp_pkg::PH_REALMLEN:
            begin
                if (v == 0)
                begin
                    cur_check_term = 1;
                    return next_component();
                end
                enter(ccsp_pkg::PH_REALMBYTE);
            end
            ccsp_pkg::PH_COMPLEN:
            begin
                if (v == 0)
                    return end_component();
                enter(ccsp_pkg::PH_COMPBYTE);
            end
            ccsp_pkg::PH_KEYLEN:
                enter(v == 0 ? ccsp_pkg::PH_AUTHTIME : ccsp_pkg::PH_KEYBYTE);
            ccsp_pkg::PH_NADDR:
            begin
                cur_entries = v;
                enter(v == 0 ? ccsp_pkg::PH_NAUTH : ccsp_pkg::PH_ADDRTYPE);
            end
            ccsp_pkg::PH_ADDRLEN:
                if (v == 0) end_addr(); else enter(ccsp_pkg::PH_ADDRBYTE);
            ccsp_pkg::PH_NAUTH:
            begin
                cur_entries = v;
                enter(v == 0 ? ccsp_pkg::PH_TKTLEN : ccsp_pkg::PH_AUTHTYPE);
            end
            ccsp_pkg::PH_AUTHLEN:
                if (v == 0) end_auth(); else enter(ccsp_pkg::PH_AUTHBYTE);
            ccsp_pkg::PH_TKTLEN:
                enter(v == 0 ? ccsp_pkg::PH_TKT2LEN : ccsp_pkg::PH_TKTBYTE);
            ccsp_pkg::PH_TKT2LEN:
            begin
                if (v == 0)
                    return end_credential();
                enter(ccsp_pkg::PH_TKT2BYTE);
            end
            default: enter(p + 5'd1);
        endcase
        return 1'b0;
    endfunction

    function automatic ccsp_pkg::ccsp_result_t parse_byte(input logic [7:0] b,
                                                          input logic fin);
        ccsp_pkg::ccsp_result_t r;
        int sz;
        r = '0;
        if (cur_error == ccsp_pkg::ST_OK && cur_check_term)
        begin
            cur_check_term = 0;
            if (b != ccsp_pkg::TERM_BYTE)
                flag_error(ccsp_pkg::ST_TERM);
        end
        if (cur_error == ccsp_pkg::ST_OK)
        begin
            sz = numeric_size(cur_phase);
            r.field_code = cur_phase;
            if (cur_phase >= ccsp_pkg::PH_NAMETYPE && cur_phase <= ccsp_pkg::PH_COMPBYTE)
                r.principal_role = cur_role;
            if (cur_phase == ccsp_pkg::PH_COMPLEN || cur_phase == ccsp_pkg::PH_COMPBYTE)
                r.component_number = cur_comp_idx;
            if (sz == 0)
            begin
                r.field_value = {24'd0, b};
                cur_remaining = cur_remaining - 1;
                if (cur_remaining == 0)
                begin
                    r.value_complete = 1;
                    r.record_done = finish_string(cur_phase);
                end
            end
            else
            begin
                if (cur_phase == ccsp_pkg::PH_FLAGS)
                    cur_accum = cur_accum | ({24'd0, b} << (8 * cur_byte_idx));
                else
                    cur_accum = {cur_accum[23:0], b};
                r.field_value = cur_accum;
                if (cur_byte_idx + 1 >= sz)
                begin
                    r.value_complete = 1;
                    r.record_done = finish_number(cur_phase, cur_accum);
                end
                else
                    cur_byte_idx = cur_byte_idx + 2'd1;
            end
        end
        r.status = cur_error;
        if (fin)
        begin
            if (r.status == ccsp_pkg::ST_OK
                && !(cur_phase == ccsp_pkg::PH_NAMETYPE
                     && cur_role == ccsp_pkg::ROLE_CLIENT && cur_byte_idx == 0))
                r.status = ccsp_pkg::ST_TRUNC;
            parser_clear();
        end
        return r;
    endfunction

    // Predict on each accepted word, compare each delivered result.
    always @(posedge clk or negedge rst_n)
    begin
        ccsp_pkg::ccsp_result_t want;
        ccsp_pkg::ccsp_result_t got;
        if (!rst_n)
        begin
            parser_clear();
            expected_results.delete();
            error_count <= 0;
            pending_count = 0;
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                got = '{field_code, field_value, value_complete, principal_role,
                        component_number, record_done, status};
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result %h", $time, got);
                    error_count <= error_count + 1;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (want !== got)
                    begin
                        $display("%0t: mismatch expected %h actual %h", $time, want, got);
                        error_count <= error_count + 1;
                    end
                end
            end
            if (item_valid && !item_stall)
                expected_results.push_back(parse_byte(byte_value, last_byte));
            pending_count = expected_results.size();
        end
    end

endmodule

// ===== sim/tb_credential_cache_stream_parser.sv =====
`timescale 1ns / 1ps

module tb_credential_cache_stream_parser;

    logic        clk;
    logic        rst_n;
    logic        item_valid;
    logic        item_stall;
    logic [7:0]  byte_value;
    logic        last_byte;
    logic        result_valid;
    logic        result_stall;
    logic [4:0]  field_code;
    logic [31:0] field_value;
    logic        value_complete;
    logic [1:0]  principal_role;
    logic [3:0]  component_number;
    logic        record_done;
    logic [1:0]  status;
    int          error_count;
    int          pending_count;
    int          idle_cycles;
    int          send_idle_pct;
    int          recv_idle_pct;
    int          words_sent;
    logic [7:0]  file_bytes[$];

    credential_cache_stream_parser dut (.*);

    ccsp_result_checker checker_i (.*);

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // Stall the result side at random on the falling edge.
    always @(negedge clk)
        result_stall <= ($urandom_range(99) < recv_idle_pct);

    // Watchdog: count cycles without any accepted word on either channel.
    always @(posedge clk)
    begin
        if ((item_valid && !item_stall) || (result_valid && !result_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 5000)
        begin
            $display("tb_credential_cache_stream_parser: done, errors");
            $finish;
        end
    end

    // Drive one word and hold it until it is taken.
    task automatic send_word(input logic [7:0] b, input logic fin);
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_valid = 0;
            @(negedge clk);
        end
        item_valid = 1;
        byte_value = b;
        last_byte = fin;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        @(negedge clk);
        item_valid = 0;
        words_sent++;
    endtask

    // Send the assembled buffer, marking its final byte.
    task automatic flush_file();
        for (int i = 0; i < file_bytes.size(); i++)
            send_word(file_bytes[i], i == file_bytes.size() - 1);
        file_bytes.delete();
    endtask

    task automatic put_num(input logic [31:0] v, input int n);
        for (int i = n - 1; i >= 0; i--)
            file_bytes.push_back(v[8*i +: 8]);
    endtask

    task automatic put_str(input int n);
        put_num(n, 4);
        for (int i = 0; i < n; i++)
            file_bytes.push_back(8'($urandom_range(255)));
    endtask

    // Principal: name type, components, realm, then components; the
    // terminator check wants a zero after realm and each component, so
    // most strings are followed by a zero byte that opens the next length field.
    task automatic put_principal(input int ncomp);
        put_num($urandom, 4);
        put_num(ncomp, 4);
        put_str($urandom_range(3));
        for (int c = 0; c < ncomp; c++)
            put_str($urandom_range(3));
    endtask

    task automatic put_credential(input int ncomp);
        int n;
        put_principal(ncomp);
        put_principal($urandom_range(2));
        put_num($urandom, 2);
        put_num($urandom, 2);
        put_str($urandom_range(3));
        for (int t = 0; t < 4; t++)
            put_num($urandom, 4);
        put_num($urandom, 1);
        put_num($urandom, 4);
        n = $urandom_range(2);
        put_num(n, 4);
        for (int a = 0; a < n; a++)
        begin
            put_num($urandom, 2);
            put_str($urandom_range(2));
        end
        n = $urandom_range(2);
        put_num(n, 4);
        for (int a = 0; a < n; a++)
        begin
            put_num($urandom, 2);
            put_str($urandom_range(2));
        end
        put_str($urandom_range(3));
        put_str($urandom_range(2));
    endtask

    task automatic put_file();
        int ncred;
        put_num(16'h0504, 2);
        put_num(1, 2);
        put_num($urandom_range(255), 1);
        put_principal($urandom_range(2));
        ncred = $urandom_range(2);
        for (int i = 0; i < ncred; i++)
            put_credential($urandom_range(3));
        // Occasionally corrupt or cut the buffer.
        if ($urandom_range(9) == 0 && file_bytes.size() > 2)
            file_bytes[$urandom_range(file_bytes.size() - 1)] = 8'($urandom_range(255));
        if ($urandom_range(9) == 0 && file_bytes.size() > 2)
            file_bytes = file_bytes[0:$urandom_range(file_bytes.size() - 1)];
    endtask

    initial
    begin
        rst_n = 0;
        item_valid = 0;
        byte_value = 0;
        last_byte = 0;
        result_stall = 0;
        idle_cycles = 0;
        words_sent = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // Directed: a minimal header block, extreme bytes, an oversized
        // component count, a truncated realm length, and a lone last byte.
        put_num(16'hFFFF, 2);
        put_num(0, 2);
        put_num(32'hFFFFFFFF, 4);
        put_num(0, 4);
        put_num(0, 4);
        flush_file();
        put_num(0, 4);
        put_num(0, 4);
        put_num(16, 4);
        flush_file();
        put_num(0, 4);
        put_num(0, 4);
        put_num(1, 4);
        file_bytes.push_back(8'h80);
        file_bytes.push_back(8'h7F);
        flush_file();
        send_word(8'hA5, 1);

        // Pause until every expected result has drained.
        while (pending_count != 0)
            @(negedge clk);

        for (int ph = 0; ph < 3; ph++)
        begin
            send_idle_pct = (ph == 0) ? 20 : (ph == 1) ? 62 : 0;
            recv_idle_pct = (ph == 0) ? 62 : (ph == 1) ? 20 : 0;
            while (words_sent < 40 + 190 * (ph + 1))
            begin
                if ($urandom_range(7) == 0)
                    for (int i = $urandom_range(1, 6); i > 0; i--)
                        file_bytes.push_back(8'($urandom_range(255)));
                else
                    put_file();
                flush_file();
            end
        end

        recv_idle_pct = 0;
        while (pending_count != 0)
            @(negedge clk);
        repeat (5) @(posedge clk);
        if (error_count == 0)
            $display("tb_credential_cache_stream_parser: done, clean");
        else
            $display("tb_credential_cache_stream_parser: done, errors");
        $finish;
    end

endmodule

// ===== credential_cache_stream_parser.f =====
+incdir+design
design/ccsp_pkg.sv
design/ccsp_step.sv
design/credential_cache_stream_parser.sv
design/ccsp_checker.sv
sim/ccsp_result_checker.sv
sim/tb_credential_cache_stream_parser.sv
